>>> src/qrs_pkg.sv
// qrs_pkg: shared types, constants and width helpers for the quadratic root solver
// no dependencies; used by every other file of the block by scoped name
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;  // default coefficient width, Q8.8
  localparam int DISC_OUT_W     = 35;  // reported discriminant width
  localparam int ROOT_W         = 32;  // Q16.16 root width
  localparam int FRAC_SHIFT     = 16;  // extra fraction bits of a root
  localparam int RADIX_SHIFT    = 32;  // radicand scaling, d * 2^32
  localparam int DISC_CAP_W     = 64;  // discriminant wraps beyond this width

  typedef enum logic [1:0] {
    KIND_A_ZERO = 2'd0,
    KIND_NONE   = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_TWO    = 2'd3
  } kind_t;

  // signed width of b*b - 4ac, capped where it wraps
  function automatic int disc_width(input int w);
    return (2 * w + 3 > DISC_CAP_W) ? DISC_CAP_W : 2 * w + 3;
  endfunction

  // bits of floor(sqrt(d * 2^32)) for a nonnegative discriminant
  function automatic int root_width(input int w);
    int xw;
    xw = disc_width(w) - 1 + RADIX_SHIFT;
    return (xw + 1) / 2;
  endfunction

  // signed width of -b * 2^16 -/+ root
  function automatic int num_width(input int w);
    int bw;
    int rw;
    bw = w + FRAC_SHIFT + 1;
    rw = root_width(w) + 1;
    return ((bw > rw) ? bw : rw) + 1;
  endfunction

endpackage

>>> src/qrs_if.sv
// qrs_in_if / qrs_out_if: valid-ready channels for coefficient and result beats
// depends on qrs_pkg
interface qrs_in_if #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if;
  logic                                  valid;
  logic                                  ready;
  qrs_pkg::kind_t                        kind;
  logic signed [qrs_pkg::DISC_OUT_W-1:0] discriminant;
  logic signed [qrs_pkg::ROOT_W-1:0]     root_low;
  logic signed [qrs_pkg::ROOT_W-1:0]     root_high;
  logic                                  overflow;

  modport source (output valid, output kind, output discriminant, output root_low,
                  output root_high, output overflow, input ready);
  modport sink   (input valid, input kind, input discriminant, input root_low,
                  input root_high, input overflow, output ready);
endinterface

>>> src/qrs_disc.sv
// qrs_disc: two-stage discriminant, products then b*b - 4ac
// depends on qrs_pkg
module qrs_disc #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               adv,
  input  logic                                               in_valid,
  input  logic signed [COEF_WIDTH-1:0]                       a_in,
  input  logic signed [COEF_WIDTH-1:0]                       b_in,
  input  logic signed [COEF_WIDTH-1:0]                       c_in,
  output logic                                               out_valid,
  output logic signed [qrs_pkg::disc_width(COEF_WIDTH)-1:0] disc,
  output logic signed [COEF_WIDTH-1:0]                       a_out,
  output logic signed [COEF_WIDTH-1:0]                       b_out
);
  localparam int W  = COEF_WIDTH;
  localparam int DW = qrs_pkg::disc_width(COEF_WIDTH);

  logic                  v1;
  logic                  v2;
  logic signed [2*W-1:0] bb;
  logic signed [2*W-1:0] ac;
  logic signed [W-1:0]   a1;
  logic signed [W-1:0]   b1;
  logic signed [DW-1:0]  d2;
  logic signed [W-1:0]   a2;
  logic signed [W-1:0]   b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb <= b_in * b_in;
      ac <= a_in * c_in;
      a1 <= a_in;
      b1 <= b_in;
      // wraps modulo 2^DW when the capped width is reached
      d2 <= DW'(bb) - (DW'(ac) <<< 2);
      a2 <= a1;
      b2 <= b1;
    end
  end

  assign out_valid = v2;
  assign disc      = d2;
  assign a_out     = a2;
  assign b_out     = b2;
endmodule

>>> src/qrs_sqrt.sv
// qrs_sqrt: pipelined restoring integer square root, one root bit per stage
// depends on qrs_pkg
module qrs_sqrt #(
  parameter int RW    = qrs_pkg::root_width(qrs_pkg::COEF_WIDTH_DEF),
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [2*RW-1:0]  x_in,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [RW-1:0]    root,
  output logic [TAG_W-1:0] tag_out
);
  localparam int XW    = 2 * RW;
  localparam int REM_W = RW + 2;

  logic             vld_s  [0:RW];
  logic [XW-1:0]    x_s    [0:RW];
  logic [REM_W-1:0] rem_s  [0:RW];
  logic [RW-1:0]    root_s [0:RW];
  logic [TAG_W-1:0] tag_s  [0:RW];

  assign vld_s[0]  = in_valid;
  assign x_s[0]    = x_in;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign tag_s[0]  = tag_in;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic             vld;
    logic [XW-1:0]    x;
    logic [REM_W-1:0] rem;
    logic [RW-1:0]    rt;
    logic [TAG_W-1:0] tag;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;
    logic [REM_W-1:0] rem_next;
    logic [RW-1:0]    rt_next;

    always_comb begin
      // bring down the next two radicand bits
      rem_sh   = {rem_s[i][RW-1:0], x_s[i][XW-1 -: 2]};
      trial    = {root_s[i], 2'b01};
      take     = (rem_sh >= trial);
      rem_next = take ? (rem_sh - trial) : rem_sh;
      rt_next  = {root_s[i][RW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (adv) begin
        vld <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x   <= x_s[i] << 2;
        rem <= rem_next;
        rt  <= rt_next;
        tag <= tag_s[i];
      end
    end

    assign vld_s[i+1]  = vld;
    assign x_s[i+1]    = x;
    assign rem_s[i+1]  = rem;
    assign root_s[i+1] = rt;
    assign tag_s[i+1]  = tag;
  end

  assign out_valid = vld_s[RW];
  assign root      = root_s[RW];
  assign tag_out   = tag_s[RW];
endmodule

>>> src/qrs_div.sv
// qrs_div: pipelined restoring unsigned divider, one quotient bit per stage
// depends on qrs_pkg
module qrs_div #(
  parameter int NUM_W = qrs_pkg::num_width(qrs_pkg::COEF_WIDTH_DEF),
  parameter int DEN_W = qrs_pkg::COEF_WIDTH_DEF + 1,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] tag_out
);
  logic             vld_s [0:NUM_W];
  logic [NUM_W-1:0] n_s   [0:NUM_W];
  logic [DEN_W-1:0] rem_s [0:NUM_W];
  logic [NUM_W-1:0] q_s   [0:NUM_W];
  logic [DEN_W-1:0] d_s   [0:NUM_W];
  logic [TAG_W-1:0] tag_s [0:NUM_W];

  assign vld_s[0] = in_valid;
  assign n_s[0]   = num;
  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign d_s[0]   = den;
  assign tag_s[0] = tag_in;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             vld;
    logic [NUM_W-1:0] n;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] q;
    logic [DEN_W-1:0] d;
    logic [TAG_W-1:0] tag;
    logic [DEN_W:0]   rs;
    logic             take;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
      rs       = {rem_s[i], n_s[i][NUM_W-1]};
      take     = (rs >= {1'b0, d_s[i]});
      rem_next = take ? DEN_W'(rs - {1'b0, d_s[i]}) : rs[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (adv) begin
        vld <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n   <= n_s[i] << 1;
        rem <= rem_next;
        q   <= {q_s[i][NUM_W-2:0], take};
        d   <= d_s[i];
        tag <= tag_s[i];
      end
    end

    assign vld_s[i+1] = vld;
    assign n_s[i+1]   = n;
    assign rem_s[i+1] = rem;
    assign q_s[i+1]   = q;
    assign d_s[i+1]   = d;
    assign tag_s[i+1] = tag;
  end

  assign out_valid = vld_s[NUM_W];
  assign quot      = q_s[NUM_W];
  assign tag_out   = tag_s[NUM_W];
endmodule

>>> src/quadratic_root_solver_unit.sv
// quadratic_root_solver_unit: top level, discriminant, square root and root division
// depends on qrs_pkg, qrs_if, qrs_disc, qrs_sqrt, qrs_div
//
// Solves a*x^2 + b*x + c = 0 for signed Q8.8 coefficients, one equation per beat.
// The block accepts a coefficient beat in every cycle while the result side does not
// stall and returns one result beat per equation, in order. The pipeline holds two
// stages of discriminant (products, then the subtract), one classify stage, one stage
// per root bit in the square root, one stage for the numerators, one stage per quotient
// bit in the two parallel dividers, and the output register. Every stage moves only when
// the output register is empty or being taken, so a stall at the result side holds
// the whole pipe and stops new coefficient beats the same cycle. The result gives the
// kind (a zero, no real roots, double root, two roots), the exact discriminant
// b*b - 4ac with 16 fraction bits, both roots in Q16.16 truncated toward zero and an
// overflow flag when either root saturated. Roots and overflow read zero when a is
// zero or the discriminant is negative.
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  qrs_in_if.sink   coef,
  qrs_out_if.source result
);
  localparam int W      = COEF_WIDTH;
  localparam int DW     = qrs_pkg::disc_width(COEF_WIDTH);
  localparam int DM     = DW - 1;
  localparam int RW     = qrs_pkg::root_width(COEF_WIDTH);
  localparam int XW     = 2 * RW;
  localparam int NW     = qrs_pkg::num_width(COEF_WIDTH);
  localparam int DNW    = W + 1;
  localparam int BW     = W + qrs_pkg::FRAC_SHIFT + 1;
  localparam int DOW    = qrs_pkg::DISC_OUT_W;
  localparam int RTW    = qrs_pkg::ROOT_W;
  localparam int QX     = (NW > RTW + 1) ? NW : RTW + 1;
  localparam int TAG_S  = 2 + DOW + BW + DNW;
  localparam int TAG_D  = 2 + DOW + 1;

  localparam logic [QX-1:0]  NEG_LIM = QX'(33'h0_8000_0000);
  localparam logic [QX-1:0]  POS_LIM = QX'(33'h0_7FFF_FFFF);
  localparam logic [RTW-1:0] SAT_NEG = 32'h8000_0000;
  localparam logic [RTW-1:0] SAT_POS = 32'h7FFF_FFFF;

  // whole pipe advances when the output slot is empty or being taken
  logic adv;
  assign adv        = !result.valid || result.ready;
  assign coef.ready = adv;

  // discriminant stages
  logic                 d_vld;
  logic signed [DW-1:0] d_val;
  logic signed [W-1:0]  d_a;
  logic signed [W-1:0]  d_b;

  qrs_disc #(
    .COEF_WIDTH (W)
  ) u_disc (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (coef.valid),
    .a_in      (coef.coef_a),
    .b_in      (coef.coef_b),
    .c_in      (coef.coef_c),
    .out_valid (d_vld),
    .disc      (d_val),
    .a_out     (d_a),
    .b_out     (d_b)
  );

  // classify stage: kind, -b * 2^16, 2a and the scaled radicand
  qrs_pkg::kind_t       kind_next;
  logic signed [W:0]    negb;
  logic                 p_vld;
  qrs_pkg::kind_t       p_kind;
  logic [DOW-1:0]       p_disc;
  logic signed [BW-1:0] p_base;
  logic signed [DNW-1:0] p_den;
  logic [XW-1:0]        p_x;

  always_comb begin
    if (d_a == '0) begin
      kind_next = qrs_pkg::KIND_A_ZERO;
    end else if (d_val[DW-1]) begin
      kind_next = qrs_pkg::KIND_NONE;
    end else if (d_val == '0) begin
      kind_next = qrs_pkg::KIND_DOUBLE;
    end else begin
      kind_next = qrs_pkg::KIND_TWO;
    end
    negb = -((W+1)'(d_b));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_kind <= kind_next;
      p_disc <= DOW'(d_val);
      p_base <= {negb, {qrs_pkg::FRAC_SHIFT{1'b0}}};
      p_den  <= {d_a, 1'b0};
      // only a nonnegative discriminant reaches a real root
      p_x    <= XW'({d_val[DM-1:0], {qrs_pkg::RADIX_SHIFT{1'b0}}});
    end
  end

  // square root pipeline, side data rides along in the tag
  logic             s_vld;
  logic [RW-1:0]    s_root;
  logic [TAG_S-1:0] s_tag;

  qrs_sqrt #(
    .RW    (RW),
    .TAG_W (TAG_S)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p_vld),
    .x_in      (p_x),
    .tag_in    ({p_kind, p_disc, p_base, p_den}),
    .out_valid (s_vld),
    .root      (s_root),
    .tag_out   (s_tag)
  );

  qrs_pkg::kind_t        s_kind;
  logic [DOW-1:0]        s_disc;
  logic signed [BW-1:0]  s_base;
  logic signed [DNW-1:0] s_den;

  assign s_kind = qrs_pkg::kind_t'(s_tag[TAG_S-1 -: 2]);
  assign s_disc = s_tag[TAG_S-3 -: DOW];
  assign s_base = s_tag[BW+DNW-1 -: BW];
  assign s_den  = s_tag[DNW-1:0];

  // numerator stage: -b*2^16 -/+ root, split into sign and magnitude
  logic signed [NW-1:0] nb;
  logic signed [NW-1:0] nr;
  logic signed [NW-1:0] nlo;
  logic signed [NW-1:0] nhi;
  logic [NW-1:0]        mag_lo_next;
  logic [NW-1:0]        mag_hi_next;
  logic [DNW-1:0]       dmag_next;

  always_comb begin
    nb          = NW'(s_base);
    nr          = signed'(NW'(s_root));
    nlo         = nb - nr;
    nhi         = nb + nr;
    mag_lo_next = nlo[NW-1] ? NW'(-nlo) : NW'(nlo);
    mag_hi_next = nhi[NW-1] ? NW'(-nhi) : NW'(nhi);
    dmag_next   = s_den[DNW-1] ? DNW'(-s_den) : DNW'(s_den);
  end

  logic           n_vld;
  qrs_pkg::kind_t n_kind;
  logic [DOW-1:0] n_disc;
  logic [NW-1:0]  n_mag_lo;
  logic [NW-1:0]  n_mag_hi;
  logic [DNW-1:0] n_dmag;
  logic           n_neg_lo;
  logic           n_neg_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_kind   <= s_kind;
      n_disc   <= s_disc;
      n_mag_lo <= mag_lo_next;
      n_mag_hi <= mag_hi_next;
      n_dmag   <= dmag_next;
      n_neg_lo <= nlo[NW-1] ^ s_den[DNW-1];
      n_neg_hi <= nhi[NW-1] ^ s_den[DNW-1];
    end
  end

  // two dividers in lockstep, the low one carries the side data
  logic             q_vld;
  logic             q_vld_lo;
  logic             q_vld_hi;
  logic [NW-1:0]    q_lo;
  logic [NW-1:0]    q_hi;
  logic [TAG_D-1:0] q_tag;
  logic             q_neg_hi;

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (DNW),
    .TAG_W (TAG_D)
  ) u_div_lo (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (n_vld),
    .num       (n_mag_lo),
    .den       (n_dmag),
    .tag_in    ({n_kind, n_disc, n_neg_lo}),
    .out_valid (q_vld_lo),
    .quot      (q_lo),
    .tag_out   (q_tag)
  );

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (DNW),
    .TAG_W (1)
  ) u_div_hi (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (n_vld),
    .num       (n_mag_hi),
    .den       (n_dmag),
    .tag_in    (n_neg_hi),
    .out_valid (q_vld_hi),
    .quot      (q_hi),
    .tag_out   (q_neg_hi)
  );

  // both dividers move together, so their valid bits agree
  assign q_vld = q_vld_lo && q_vld_hi;

  // apply sign and clamp to Q16.16, overflow flag in the top bit
  function automatic logic [RTW:0] saturate(input logic [QX-1:0] q, input logic neg);
    logic [RTW:0] r;
    if (neg) begin
      if (q > NEG_LIM) begin
        r = {1'b1, SAT_NEG};
      end else begin
        r = {1'b0, RTW'(-q)};
      end
    end else begin
      if (q > POS_LIM) begin
        r = {1'b1, SAT_POS};
      end else begin
        r = {1'b0, q[RTW-1:0]};
      end
    end
    return r;
  endfunction

  qrs_pkg::kind_t q_kind;
  logic [RTW:0]   sat_lo;
  logic [RTW:0]   sat_hi;
  logic           real_roots;

  always_comb begin
    q_kind     = qrs_pkg::kind_t'(q_tag[TAG_D-1 -: 2]);
    sat_lo     = saturate(QX'(q_lo), q_tag[0]);
    sat_hi     = saturate(QX'(q_hi), q_neg_hi);
    real_roots = (q_kind == qrs_pkg::KIND_DOUBLE) || (q_kind == qrs_pkg::KIND_TWO);
  end

  // output register
  logic                  o_vld;
  qrs_pkg::kind_t        o_kind;
  logic signed [DOW-1:0] o_disc;
  logic signed [RTW-1:0] o_lo;
  logic signed [RTW-1:0] o_hi;
  logic                  o_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_kind <= q_kind;
      o_disc <= q_tag[DOW:1];
      o_lo   <= real_roots ? sat_lo[RTW-1:0] : '0;
      o_hi   <= real_roots ? sat_hi[RTW-1:0] : '0;
      o_ovf  <= real_roots && (sat_lo[RTW] || sat_hi[RTW]);
    end
  end

  assign result.valid        = o_vld;
  assign result.kind         = o_kind;
  assign result.discriminant = o_disc;
  assign result.root_low     = o_lo;
  assign result.root_high    = o_hi;
  assign result.overflow     = o_ovf;
endmodule

>>> src/qrs_checker.sv
// qrs_checker: port-level assertions for the quadratic root solver, and its bind
// depends on qrs_pkg and quadratic_root_solver_unit
module qrs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [1:0]                            kind,
  input logic signed [qrs_pkg::DISC_OUT_W-1:0] discriminant,
  input logic signed [qrs_pkg::ROOT_W-1:0]     root_low,
  input logic signed [qrs_pkg::ROOT_W-1:0]     root_high,
  input logic                                  overflow
);
  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(discriminant)
      && $stable(root_low) && $stable(root_high) && $stable(overflow))
    else $error("stalled result beat changed");

  // a stall at the result side holds off coefficient beats
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("coefficient beat taken during result stall");

  // no real roots: roots and overflow read zero
  a_no_roots_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == qrs_pkg::KIND_A_ZERO || kind == qrs_pkg::KIND_NONE)
      |-> root_low == '0 && root_high == '0 && !overflow)
    else $error("roots reported without real roots");

  // double root: zero discriminant and equal roots
  a_double_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == qrs_pkg::KIND_DOUBLE |-> discriminant == '0 && root_low == root_high)
    else $error("double root inconsistent");
endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (coef.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .kind         (result.kind),
  .discriminant (result.discriminant),
  .root_low     (result.root_low),
  .root_high    (result.root_high),
  .overflow     (result.overflow)
);
